>>> hdl/axsup_pkg.sv
// Shared types, codes and helper functions of the axis supervisor.
package axsup_pkg;

	// Motion commands are carried out only when this is set.
	localparam logic MOTION_IMPLEMENTED = 1'b1;

	// Depth of the queue between the front and the back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Configuration register indexes.
	localparam logic [1:0] REG_ALLOW_UNCAL = 2'd0;
	localparam logic [1:0] REG_SOFT_MIN    = 2'd1;
	localparam logic [1:0] REG_SOFT_MAX    = 2'd2;

	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

	// Raw command codes on the input port.
	typedef enum logic [3:0] {
		CMD_ENABLE  = 4'd0,
		CMD_DISABLE = 4'd1,
		CMD_STOP    = 4'd2,
		CMD_QSTOP   = 4'd3,
		CMD_MOVE_REL = 4'd4,
		CMD_MOVE_ABS = 4'd5,
		CMD_CFG_CHG = 4'd6,
		CMD_CAL_DONE = 4'd7,
		CMD_RT_TICK = 4'd8,
		CMD_BG_TICK = 4'd9
	} cmd_t;

	// Classified operation handed from the front to the back.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_ENABLE,
		OP_DISABLE,
		OP_STOP,
		OP_QSTOP,
		OP_MOVE,
		OP_CFG_CHG,
		OP_CAL_DONE,
		OP_RT_TICK,
		OP_BG_TICK
	} op_t;

	// Axis modes.
	typedef enum logic [2:0] {
		MODE_SAFE     = 3'd0,
		MODE_CONFIG   = 3'd1,
		MODE_ARMED    = 3'd2,
		MODE_READY    = 3'd3,
		MODE_MOTION   = 3'd4,
		MODE_STOPPING = 3'd5,
		MODE_FAULT    = 3'd6,
		MODE_CAL      = 3'd7
	} mode_t;

	// Logged event codes.
	typedef enum logic [2:0] {
		LOG_NONE    = 3'd0,
		LOG_ENABLE  = 3'd1,
		LOG_DISABLE = 3'd2,
		LOG_STOP    = 3'd3,
		LOG_QSTOP   = 3'd4
	} evt_t;

	// Live status flags that come with every beat.
	typedef struct packed {
		logic fault_active;
		logic safe_mode;
		logic calibration_valid;
		logic arming_only;
		logic controlled_motion;
		logic trajectory_finished;
	} flags_t;

	// One classified item as it waits in the queue.
	typedef struct packed {
		op_t                op;
		logic signed [31:0] goal_um;
		logic               cal_success;
		flags_t             flags;
	} entry_t;

	// Configuration register contents.
	typedef struct packed {
		logic               allow_uncal;
		logic signed [31:0] soft_min_um;
		logic signed [31:0] soft_max_um;
	} cfg_t;

	// Mode the axis settles in when no motion is going on.
	function automatic mode_t idle_mode(input flags_t f, input logic cal_req,
			input logic enable);
		mode_t m;
		if (f.fault_active) begin
			m = MODE_FAULT;
		end else if (cal_req && !enable) begin
			m = MODE_CONFIG;
		end else if (f.safe_mode || !enable) begin
			m = MODE_SAFE;
		end else if (f.arming_only) begin
			m = MODE_ARMED;
		end else if (cal_req) begin
			m = MODE_CONFIG;
		end else begin
			m = MODE_READY;
		end
		return m;
	endfunction

	// Motion preconditions for a given enable bit.
	function automatic logic run_ok(input flags_t f, input logic cal_req,
			input logic enable);
		return !f.fault_active && !f.safe_mode && !cal_req && enable &&
			f.controlled_motion;
	endfunction

endpackage

>>> hdl/axis_supervisor_state_machine.sv
// Top level of the axis supervisor: configuration registers and the front, queue and back.
// Supervisor for one motion axis. Each input beat carries one command and a snapshot of the
// live status flags; each produces exactly one result beat with acceptance, run permission,
// axis mode, enable and done bits, the position setpoint and the logged event. The block
// takes one beat per cycle while the queue has room and results are drained. A beat is
// decoded (and a relative target summed with saturation) as it enters a two-entry queue,
// and the back executes it against the axis state and writes the result register. The
// update of mode, enable, done and setpoint in the back sets the rate, since each command
// depends on the state left by the one before. Configuration writes are always ready and
// should be issued only while the block is idle.
module axis_supervisor_state_machine import axsup_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [1:0]  cfg_index,
	input  logic        [31:0] cfg_data,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic        [3:0]  command,
	input  logic signed [31:0] amount_um,
	input  logic signed [31:0] current_pos_um,
	input  logic               cal_success,
	input  logic               fault_active,
	input  logic               safe_mode,
	input  logic               calibration_valid,
	input  logic               arming_only,
	input  logic               controlled_motion,
	input  logic               trajectory_finished,
	output logic               result_valid,
	input  logic               result_ready,
	output logic               accepted,
	output logic               run_allowed,
	output logic        [2:0]  axis_mode,
	output logic               enabled_out,
	output logic               done_out,
	output logic signed [31:0] setpoint_out_um,
	output logic        [2:0]  event_code
);

	cfg_t   cfg_q;
	flags_t flags;
	entry_t front_entry;
	entry_t head_entry;
	logic   q_full;
	logic   head_valid;
	logic   pop;
	logic   push;

	assign cfg_ready  = 1'b1;
	assign item_ready = !q_full;
	assign push       = item_valid && item_ready;

	assign flags = '{
		fault_active:        fault_active,
		safe_mode:           safe_mode,
		calibration_valid:   calibration_valid,
		arming_only:         arming_only,
		controlled_motion:   controlled_motion,
		trajectory_finished: trajectory_finished
	};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.allow_uncal <= 1'b0;
			cfg_q.soft_min_um <= S32_MIN;
			cfg_q.soft_max_um <= S32_MAX;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ALLOW_UNCAL: cfg_q.allow_uncal <= cfg_data[0];
				REG_SOFT_MIN:    cfg_q.soft_min_um <= cfg_data;
				REG_SOFT_MAX:    cfg_q.soft_max_um <= cfg_data;
				default: ;
			endcase
		end
	end

	axsup_front u_front (
		.command        (command),
		.amount_um      (amount_um),
		.current_pos_um (current_pos_um),
		.cal_success    (cal_success),
		.flags          (flags),
		.entry          (front_entry)
	);

	axsup_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (front_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	axsup_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.head_valid      (head_valid),
		.head_entry      (head_entry),
		.pop             (pop),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.accepted        (accepted),
		.run_allowed     (run_allowed),
		.axis_mode       (axis_mode),
		.enabled_out     (enabled_out),
		.done_out        (done_out),
		.setpoint_out_um (setpoint_out_um),
		.event_code      (event_code)
	);

endmodule

>>> hdl/axsup_front.sv
// Front part: decodes the command and forms the move target.
module axsup_front import axsup_pkg::*; (
	input  logic               [3:0]  command,
	input  logic signed        [31:0] amount_um,
	input  logic signed        [31:0] current_pos_um,
	input  logic                      cal_success,
	input  flags_t                    flags,
	output entry_t                    entry
);

	logic signed [32:0] sum_um;
	logic signed [31:0] rel_um;

	// Relative target, saturated to 32 bits.
	always_comb begin
		sum_um = {current_pos_um[31], current_pos_um} + {amount_um[31], amount_um};
		if (sum_um[32] != sum_um[31]) begin
			rel_um = sum_um[32] ? S32_MIN : S32_MAX;
		end else begin
			rel_um = sum_um[31:0];
		end
	end

	// Classify the command; codes with no meaning become no operation.
	always_comb begin
		entry.goal_um     = amount_um;
		entry.cal_success = cal_success;
		entry.flags       = flags;
		unique case (command)
			CMD_ENABLE:   entry.op = OP_ENABLE;
			CMD_DISABLE:  entry.op = OP_DISABLE;
			CMD_STOP:     entry.op = OP_STOP;
			CMD_QSTOP:    entry.op = OP_QSTOP;
			CMD_MOVE_REL: begin
				entry.op      = OP_MOVE;
				entry.goal_um = rel_um;
			end
			CMD_MOVE_ABS: entry.op = OP_MOVE;
			CMD_CFG_CHG:  entry.op = OP_CFG_CHG;
			CMD_CAL_DONE: entry.op = OP_CAL_DONE;
			CMD_RT_TICK:  entry.op = OP_RT_TICK;
			CMD_BG_TICK:  entry.op = OP_BG_TICK;
			default:      entry.op = OP_NONE;
		endcase
	end

endmodule

>>> hdl/axsup_queue.sv
// Short queue of classified items between the front and the back.
module axsup_queue import axsup_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head_entry
);

	entry_t              slots_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = slots_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/axsup_back.sv
// Back part: carries out each command against the axis state.
module axsup_back import axsup_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               head_valid,
	input  entry_t             head_entry,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_ready,
	output logic               accepted,
	output logic               run_allowed,
	output logic        [2:0]  axis_mode,
	output logic               enabled_out,
	output logic               done_out,
	output logic signed [31:0] setpoint_out_um,
	output logic        [2:0]  event_code
);

	mode_t              mode_q, mode_d;
	logic               enable_q, enable_d;
	logic               done_q, done_d;
	logic signed [31:0] setpoint_q, setpoint_d;
	logic               out_valid_q;

	flags_t             f;
	logic               cal_req;
	logic               done_in;
	logic               move_ok;
	logic signed [31:0] clamped_um;
	mode_t              idle_now;
	logic               acc_d;
	evt_t               evt_d;

	// Take the next item whenever the result register is free or draining.
	assign pop          = head_valid && (!out_valid_q || result_ready);
	assign result_valid = out_valid_q;

	// Shared terms of the step.
	always_comb begin
		f        = head_entry.flags;
		cal_req  = !f.calibration_valid && !cfg.allow_uncal;
		done_in  = done_q || f.trajectory_finished;
		idle_now = idle_mode(f, cal_req, enable_q);
		move_ok  = MOTION_IMPLEMENTED && run_ok(f, cal_req, enable_q) &&
			!(cfg.soft_min_um > cfg.soft_max_um);
		if (head_entry.goal_um < cfg.soft_min_um) begin
			clamped_um = cfg.soft_min_um;
		end else if (head_entry.goal_um > cfg.soft_max_um) begin
			clamped_um = cfg.soft_max_um;
		end else begin
			clamped_um = head_entry.goal_um;
		end
	end

	// Next axis state.
	always_comb begin
		mode_d     = mode_q;
		enable_d   = enable_q;
		done_d     = done_in;
		setpoint_d = setpoint_q;
		unique case (head_entry.op)
			OP_ENABLE: begin
				if (!f.fault_active) begin
					enable_d = 1'b1;
					mode_d   = idle_mode(f, cal_req, 1'b1);
				end
			end
			OP_DISABLE: begin
				enable_d = 1'b0;
				mode_d   = MODE_SAFE;
			end
			OP_STOP: begin
				done_d = 1'b1;
				mode_d = MODE_STOPPING;
			end
			OP_QSTOP: begin
				done_d   = 1'b1;
				enable_d = 1'b0;
				mode_d   = MODE_SAFE;
			end
			OP_MOVE: begin
				if (move_ok) begin
					setpoint_d = clamped_um;
					done_d     = 1'b0;
					mode_d     = MODE_MOTION;
				end
			end
			OP_CFG_CHG: begin
				if (mode_q != MODE_FAULT && mode_q != MODE_MOTION &&
						mode_q != MODE_STOPPING && mode_q != MODE_CAL) begin
					mode_d = MODE_CONFIG;
				end
			end
			OP_CAL_DONE: begin
				mode_d = head_entry.cal_success ? idle_now : MODE_CONFIG;
			end
			OP_RT_TICK: begin
				if (f.fault_active) begin
					enable_d = 1'b0;
					done_d   = 1'b1;
					mode_d   = MODE_FAULT;
				end else if (!run_ok(f, cal_req, enable_q)) begin
					done_d = 1'b1;
				end
			end
			OP_BG_TICK: begin
				// The idle mode is never stopping or motion, so one pass settles it.
				if (mode_q == MODE_STOPPING || mode_q == MODE_CONFIG ||
						(mode_q == MODE_MOTION && done_in)) begin
					mode_d = idle_now;
				end
			end
			default: ;
		endcase
	end

	// Acceptance and logged event of the step.
	always_comb begin
		acc_d = 1'b0;
		evt_d = LOG_NONE;
		unique case (head_entry.op)
			OP_ENABLE: begin
				acc_d = !f.fault_active;
				evt_d = f.fault_active ? LOG_NONE : LOG_ENABLE;
			end
			OP_DISABLE: begin
				acc_d = 1'b1;
				evt_d = LOG_DISABLE;
			end
			OP_STOP: begin
				acc_d = 1'b1;
				evt_d = LOG_STOP;
			end
			OP_QSTOP: begin
				acc_d = 1'b1;
				evt_d = LOG_QSTOP;
			end
			OP_MOVE:     acc_d = move_ok;
			OP_CFG_CHG:  acc_d = 1'b1;
			OP_CAL_DONE: acc_d = 1'b1;
			OP_RT_TICK:  acc_d = 1'b1;
			OP_BG_TICK:  acc_d = 1'b1;
			default: ;
		endcase
	end

	// Axis state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_SAFE;
			enable_q    <= 1'b0;
			done_q      <= 1'b1;
			setpoint_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q     <= mode_d;
				enable_q   <= enable_d;
				done_q     <= done_d;
				setpoint_q <= setpoint_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (pop) begin
			accepted        <= acc_d;
			run_allowed     <= run_ok(f, cal_req, enable_d);
			axis_mode       <= mode_d;
			enabled_out     <= enable_d;
			done_out        <= done_d;
			setpoint_out_um <= setpoint_d;
			event_code      <= evt_d;
		end
	end

endmodule
